FILE: rtl/ipbf_pkg.sv
// shared types and constants for the ipv4 blocklist packet filter
package ipbf_pkg;

    localparam int HEADER_BYTES = 94;
    localparam int CNT_W        = 7;
    localparam int ETH_LEN      = 14;
    localparam int IPV4_MIN_END = 34;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    typedef enum logic [1:0] {
        MODE_BYTE = 2'd0,
        MODE_ADDR = 2'd1,
        MODE_TCP  = 2'd2,
        MODE_UDP  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CAUSE_SHORT    = 3'd0,
        CAUSE_ADDR     = 3'd1,
        CAUSE_TCP      = 3'd2,
        CAUSE_UDP      = 3'd3,
        CAUSE_ALLOW    = 3'd4,
        CAUSE_DENY     = 3'd5,
        CAUSE_SHORT_L4 = 3'd6
    } t_cause;

    // frame summary captured on the last byte
    typedef struct packed {
        logic        ipv4;
        logic [31:0] src;
        logic        is_tcp;
        logic        is_udp;
        logic        l4_short;
        logic [15:0] port;
    } t_frame;

endpackage

FILE: rtl/ipbf_parse.sv
// header byte store and frame field extraction
module ipbf_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_byte_en,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output ipbf_pkg::t_frame      o_frame
);
    import ipbf_pkg::*;

    logic [7:0]       r_hdr [HEADER_BYTES];
    logic [CNT_W-1:0] r_seen;
    logic [CNT_W-1:0] n_seen;

    // byte count, saturating at the header size, cleared after last byte
    always_comb begin
        n_seen = r_seen;
        if (i_byte_en) begin
            if (i_last) n_seen = '0;
            else if (r_seen < CNT_W'(HEADER_BYTES)) n_seen = r_seen + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seen <= '0;
        else          r_seen <= n_seen;
    end

    // header store, one shift-free slot per byte position
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < HEADER_BYTES; k++) begin
            if (i_byte_en && r_seen == CNT_W'(k)) r_hdr[k] <= i_byte;
        end
    end

    // current view with the incoming byte merged in
    logic [7:0]       v_hdr [HEADER_BYTES];
    logic [CNT_W-1:0] v_len;
    logic [3:0]       ihl;
    logic [7:0]       proto;
    logic [7:0]       need;
    logic [15:0]      port;

    always_comb begin
        for (int k = 0; k < HEADER_BYTES; k++) begin
            v_hdr[k] = (r_seen == CNT_W'(k)) ? i_byte : r_hdr[k];
        end
        v_len = (r_seen < CNT_W'(HEADER_BYTES)) ? r_seen + 1'b1 : r_seen;
        ihl   = v_hdr[14][3:0];
        proto = v_hdr[23];
        need  = 8'(ETH_LEN) + {2'b0, ihl, 2'b0} + ((proto == PROTO_TCP) ? 8'd20 : 8'd8);
        // port select over the possible l4 offsets
        port = '0;
        for (int h = 0; h < 16; h++) begin
            if (ihl == 4'(h) && ETH_LEN + 4*h + 3 < HEADER_BYTES)
                port = {v_hdr[ETH_LEN + 4*h + 2], v_hdr[ETH_LEN + 4*h + 3]};
        end
        o_frame.ipv4 = (v_len >= CNT_W'(IPV4_MIN_END))
                     && ({v_hdr[12], v_hdr[13]} == ETHERTYPE_IPV4);
        o_frame.src  = {v_hdr[26], v_hdr[27], v_hdr[28], v_hdr[29]};
        o_frame.is_tcp   = proto == PROTO_TCP;
        o_frame.is_udp   = proto == PROTO_UDP;
        o_frame.l4_short = ({1'b0, v_len} < need) || (need > 8'(HEADER_BYTES));
        o_frame.port     = port;
    end

endmodule

FILE: rtl/ipbf_rules.sv
// address and port rule tables with parallel match
module ipbf_rules #(
    parameter int RULE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [1:0]  i_mode,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_key,
    input  logic        i_enable,
    input  logic [31:0] i_src,
    input  logic [15:0] i_port,
    output logic        o_addr_hit,
    output logic        o_tcp_hit,
    output logic        o_udp_hit
);
    import ipbf_pkg::*;

    logic [31:0]             r_addr [RULE_ENTRIES];
    logic [15:0]             r_tcp  [RULE_ENTRIES];
    logic [15:0]             r_udp  [RULE_ENTRIES];
    logic [RULE_ENTRIES-1:0] r_addr_on;
    logic [RULE_ENTRIES-1:0] r_tcp_on;
    logic [RULE_ENTRIES-1:0] r_udp_on;

    // table writes; slots past the table are ignored
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RULE_ENTRIES; k++) begin
            if (i_wr_en && int'(i_slot) == k) begin
                case (t_mode'(i_mode))
                    MODE_ADDR: r_addr[k] <= i_key;
                    MODE_TCP:  r_tcp[k]  <= i_key[15:0];
                    MODE_UDP:  r_udp[k]  <= i_key[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_on <= '0;
            r_tcp_on  <= '0;
            r_udp_on  <= '0;
        end else begin
            for (int k = 0; k < RULE_ENTRIES; k++) begin
                if (i_wr_en && int'(i_slot) == k) begin
                    case (t_mode'(i_mode))
                        MODE_ADDR: r_addr_on[k] <= i_enable;
                        MODE_TCP:  r_tcp_on[k]  <= i_enable;
                        MODE_UDP:  r_udp_on[k]  <= i_enable;
                        default: ;
                    endcase
                end
            end
        end
    end

    // parallel compares
    always_comb begin
        o_addr_hit = 1'b0;
        o_tcp_hit  = 1'b0;
        o_udp_hit  = 1'b0;
        for (int k = 0; k < RULE_ENTRIES; k++) begin
            o_addr_hit |= r_addr_on[k] && r_addr[k] == i_src;
            o_tcp_hit  |= r_tcp_on[k]  && r_tcp[k]  == i_port;
            o_udp_hit  |= r_udp_on[k]  && r_udp[k]  == i_port;
        end
    end

endmodule

FILE: rtl/ipbf_sources.sv
// per-source hit table with match, insert and increment
module ipbf_sources #(
    parameter int SOURCE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [31:0] i_src,
    output logic [63:0] o_hits
);
    import ipbf_pkg::*;

    logic [31:0]               r_addr [SOURCE_ENTRIES];
    logic [63:0]               r_cnt  [SOURCE_ENTRIES];
    logic [SOURCE_ENTRIES-1:0] r_used;
    logic [SOURCE_ENTRIES-1:0] match;
    logic [SOURCE_ENTRIES-1:0] free_first;
    logic                      any_match;
    logic                      seen_free;
    logic [63:0]               hit_cnt;

    // match vector and first free slot
    always_comb begin
        seen_free = 1'b0;
        hit_cnt   = '0;
        for (int k = 0; k < SOURCE_ENTRIES; k++) begin
            match[k]      = r_used[k] && r_addr[k] == i_src;
            free_first[k] = !r_used[k] && !seen_free;
            if (!r_used[k]) seen_free = 1'b1;
            if (match[k]) hit_cnt |= r_cnt[k];
        end
        any_match = |match;
        if (any_match)      o_hits = hit_cnt + 64'd1;
        else if (seen_free) o_hits = 64'd1;
        else                o_hits = '0;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SOURCE_ENTRIES; k++) begin
            if (i_en && match[k]) r_cnt[k] <= r_cnt[k] + 64'd1;
            else if (i_en && !any_match && free_first[k]) begin
                r_cnt[k]  <= 64'd1;
                r_addr[k] <= i_src;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_used <= '0;
        else if (i_en && !any_match) r_used <= r_used | free_first;
    end

    // a source never sits in two slots
    assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot0(match))
        else $error("source in two slots");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(free_first))
        else $error("more than one insert slot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && any_match |=> $countones(r_used) == $countones($past(r_used)))
        else $error("hit changed the used set");

endmodule

FILE: rtl/ipv4_blocklist_packet_filter.sv
// ipv4 blocklist packet filter top level
//  channel | signals                                    | direction
//  in      | i_valid/o_ready, mode byte last slot key en | request in
//  out     | o_valid/i_ready, verdict cause totals hits | request out
//  cfg     | i_cfg_we/i_cfg_wdata                       | register write
// one request per cycle while o_ready is high; a verdict appears in the cycle after the last byte
// set by the single result register; all matching is combinational in one pass
// synchronous active-low reset clears counts, valid bits and the byte counter
// the input stalls only when the result register is full and not being taken
module ipv4_blocklist_packet_filter #(
    parameter int RULE_ENTRIES   = 16,
    parameter int SOURCE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_pkt_byte,
    input  logic        i_pkt_last,
    input  logic [3:0]  i_rule_slot,
    input  logic [31:0] i_rule_key,
    input  logic        i_rule_enable,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_verdict,
    output logic [2:0]  o_cause,
    output logic [63:0] o_pass_total,
    output logic [63:0] o_drop_total,
    output logic [63:0] o_source_hits
);
    import ipbf_pkg::*;

    logic        r_allow;
    logic        acc;
    logic        byte_en;
    logic        rule_en;
    logic        judge;
    t_frame      frame;
    logic        addr_hit;
    logic        tcp_hit;
    logic        udp_hit;
    logic [63:0] hits;
    logic [63:0] r_pass;
    logic [63:0] r_drop;
    logic [63:0] n_pass;
    logic [63:0] n_drop;
    logic        verdict;
    t_cause      cause;

    assign o_ready = !o_valid || i_ready;
    assign acc     = i_valid && o_ready;
    assign byte_en = acc && t_mode'(i_mode) == MODE_BYTE;
    assign rule_en = acc && t_mode'(i_mode) != MODE_BYTE;
    assign judge   = byte_en && i_pkt_last;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)     r_allow <= 1'b0;
        else if (i_cfg_we) r_allow <= i_cfg_wdata;
    end

    ipbf_parse u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_byte_en(byte_en),
        .i_byte(i_pkt_byte), .i_last(i_pkt_last), .o_frame(frame)
    );

    ipbf_rules #(.RULE_ENTRIES(RULE_ENTRIES)) u_rules (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr_en(rule_en), .i_mode(i_mode),
        .i_slot(i_rule_slot), .i_key(i_rule_key), .i_enable(i_rule_enable),
        .i_src(frame.src), .i_port(frame.port),
        .o_addr_hit(addr_hit), .o_tcp_hit(tcp_hit), .o_udp_hit(udp_hit)
    );

    ipbf_sources #(.SOURCE_ENTRIES(SOURCE_ENTRIES)) u_sources (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(judge && frame.ipv4),
        .i_src(frame.src), .o_hits(hits)
    );

    // verdict decision
    always_comb begin
        verdict = 1'b0;
        n_pass  = r_pass;
        n_drop  = r_drop;
        if (!frame.ipv4) begin
            cause = CAUSE_SHORT;
        end else if (addr_hit) begin
            cause = CAUSE_ADDR;
            verdict = 1'b1;
        end else if ((frame.is_tcp || frame.is_udp) && frame.l4_short) begin
            cause = CAUSE_SHORT_L4;
        end else if (frame.is_tcp && tcp_hit) begin
            cause = CAUSE_TCP;
            verdict = 1'b1;
        end else if (frame.is_udp && udp_hit) begin
            cause = CAUSE_UDP;
            verdict = 1'b1;
        end else if (r_allow) begin
            cause = CAUSE_ALLOW;
            n_pass = r_pass + 64'd1;
        end else begin
            cause = CAUSE_DENY;
            verdict = 1'b1;
        end
        if (verdict) n_drop = r_drop + 64'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass  <= '0;
            r_drop  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (judge) begin
                r_pass <= n_pass;
                r_drop <= n_drop;
            end
            if (o_ready) o_valid <= judge;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (judge) begin
            o_verdict     <= verdict;
            o_cause       <= cause;
            o_pass_total  <= n_pass;
            o_drop_total  <= n_drop;
            o_source_hits <= frame.ipv4 ? hits : 64'd0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cause))
        else $error("result lost under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        judge |=> (r_pass != $past(r_pass)) + (r_drop != $past(r_drop)) <= 1)
        else $error("both totals moved");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_verdict == (o_cause == CAUSE_ADDR || o_cause == CAUSE_TCP
            || o_cause == CAUSE_UDP || o_cause == CAUSE_DENY))
        else $error("verdict and cause disagree");

endmodule

FILE: dv/ipv4_blocklist_packet_filter_checker.sv
// checker for the ipv4 blocklist packet filter: mirrors its tables and compares verdicts
`timescale 1ns / 1ps
module ipv4_blocklist_packet_filter_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_pkt_byte,
    input  logic        i_pkt_last,
    input  logic [3:0]  i_rule_slot,
    input  logic [31:0] i_rule_key,
    input  logic        i_rule_enable,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_verdict,
    input  logic [2:0]  i_cause,
    input  logic [63:0] i_pass_total,
    input  logic [63:0] i_drop_total,
    input  logic [63:0] i_source_hits,
    output int          o_errors,
    output int          o_pending,
    output int          o_verdicts,
    output int          o_drops
);
    import ipbf_pkg::*;

    localparam int RULES   = 16;
    localparam int SOURCES = 64;

    typedef struct {
        logic        verdict;
        t_cause      cause;
        logic [63:0] pass_total;
        logic [63:0] drop_total;
        logic [63:0] hits;
    } t_verdict;

    t_verdict    verdict_queue[$];
    logic [7:0]  hdr[HEADER_BYTES];
    int          seen;
    logic [31:0] addr_rule[RULES];
    logic        addr_on[RULES];
    logic [15:0] tcp_rule[RULES];
    logic        tcp_on[RULES];
    logic [15:0] udp_rule[RULES];
    logic        udp_on[RULES];
    logic [31:0] src_addr[SOURCES];
    logic        src_used[SOURCES];
    logic [63:0] src_count[SOURCES];
    logic [63:0] passed;
    logic [63:0] dropped;
    logic        allow_unmatched;

    assign o_pending = verdict_queue.size();

    // hit counter per source, inserting into the first free slot
    function automatic logic [63:0] count_source(logic [31:0] src);
        int free_idx;
        free_idx = -1;
        for (int i = 0; i < SOURCES; i++) begin
            if (src_used[i] && src_addr[i] == src) begin
                src_count[i] += 1;
                return src_count[i];
            end
            if (!src_used[i] && free_idx < 0) free_idx = i;
        end
        if (free_idx < 0) return 0;
        src_used[free_idx]  = 1'b1;
        src_addr[free_idx]  = src;
        src_count[free_idx] = 1;
        return 1;
    endfunction

    // decide the verdict of the frame held in hdr
    function automatic t_verdict judge_frame();
        t_verdict    v;
        logic [31:0] src;
        logic [7:0]  proto;
        int          l4;
        int          need;
        logic [15:0] port;
        logic        hit;
        v.verdict = 1'b0;
        v.hits    = '0;
        v.cause   = CAUSE_SHORT;
        if (seen >= ETH_LEN && {hdr[12], hdr[13]} == ETHERTYPE_IPV4 && seen >= IPV4_MIN_END) begin
            src    = {hdr[26], hdr[27], hdr[28], hdr[29]};
            v.hits = count_source(src);
            hit    = 1'b0;
            for (int i = 0; i < RULES; i++) if (addr_on[i] && addr_rule[i] == src) hit = 1'b1;
            proto = hdr[23];
            l4    = ETH_LEN + int'(hdr[14][3:0]) * 4;
            if (hit) begin
                v.cause = CAUSE_ADDR;
            end else if (proto == PROTO_TCP || proto == PROTO_UDP) begin
                need = l4 + ((proto == PROTO_TCP) ? 20 : 8);
                if (seen < need || need > HEADER_BYTES) begin
                    v.cause = CAUSE_SHORT_L4;
                end else begin
                    port = {hdr[l4 + 2], hdr[l4 + 3]};
                    for (int i = 0; i < RULES; i++) begin
                        if (proto == PROTO_TCP && tcp_on[i] && tcp_rule[i] == port) hit = 1'b1;
                        if (proto == PROTO_UDP && udp_on[i] && udp_rule[i] == port) hit = 1'b1;
                    end
                    if (hit) v.cause = (proto == PROTO_TCP) ? CAUSE_TCP : CAUSE_UDP;
                end
            end
            if (v.cause == CAUSE_SHORT)
                v.cause = allow_unmatched ? CAUSE_ALLOW : CAUSE_DENY;
            if (v.cause == CAUSE_ALLOW) begin
                passed += 1;
            end else if (v.cause != CAUSE_SHORT_L4) begin
                dropped  += 1;
                v.verdict = 1'b1;
            end
        end
        v.pass_total = passed;
        v.drop_total = dropped;
        return v;
    endfunction

    // track requests in, compare verdicts out
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            seen            = 0;
            passed          = '0;
            dropped         = '0;
            allow_unmatched = 1'b0;
            o_errors        <= 0;
            o_verdicts      <= 0;
            o_drops         <= 0;
            for (int i = 0; i < RULES; i++) begin
                addr_on[i] = 1'b0;
                tcp_on[i]  = 1'b0;
                udp_on[i]  = 1'b0;
            end
            for (int i = 0; i < SOURCES; i++) src_used[i] = 1'b0;
        end else begin
            if (i_cfg_we) allow_unmatched = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                o_verdicts <= o_verdicts + 1;
                if (i_verdict) o_drops <= o_drops + 1;
                if (verdict_queue.size() == 0) begin
                    $display("%0t: unexpected verdict cause %0d", $time, i_cause);
                    o_errors <= o_errors + 1;
                end else begin
                    want = verdict_queue.pop_front();
                    if (i_verdict !== want.verdict || i_cause !== want.cause ||
                        i_pass_total !== want.pass_total ||
                        i_drop_total !== want.drop_total ||
                        i_source_hits !== want.hits) begin
                        $display("%0t: mismatch exp v%0d c%0d p%0d d%0d h%0d",
                                 $time, want.verdict, want.cause, want.pass_total,
                                 want.drop_total, want.hits);
                        $display("%0t:          got v%0d c%0d p%0d d%0d h%0d",
                                 $time, i_verdict, i_cause, i_pass_total,
                                 i_drop_total, i_source_hits);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_in_ready) begin
                case (t_mode'(i_mode))
                    MODE_ADDR: begin
                        addr_rule[i_rule_slot] = i_rule_key;
                        addr_on[i_rule_slot]   = i_rule_enable;
                    end
                    MODE_TCP: begin
                        tcp_rule[i_rule_slot] = i_rule_key[15:0];
                        tcp_on[i_rule_slot]   = i_rule_enable;
                    end
                    MODE_UDP: begin
                        udp_rule[i_rule_slot] = i_rule_key[15:0];
                        udp_on[i_rule_slot]   = i_rule_enable;
                    end
                    default: begin
                        if (seen < HEADER_BYTES) begin
                            hdr[seen] = i_pkt_byte;
                            seen      = seen + 1;
                        end
                        if (i_pkt_last) begin
                            verdict_queue.push_back(judge_frame());
                            seen = 0;
                        end
                    end
                endcase
            end
        end
    end

endmodule

FILE: dv/ipv4_blocklist_packet_filter_test.sv
// stimulus and verdict for the ipv4 blocklist packet filter
`timescale 1ns / 1ps
module ipv4_blocklist_packet_filter_test;
    import ipbf_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [7:0]  pkt_byte;
    logic        pkt_last;
    logic [3:0]  rule_slot;
    logic [31:0] rule_key;
    logic        rule_enable;
    logic        out_valid;
    logic        out_ready;
    logic        verdict;
    logic [2:0]  cause;
    logic [63:0] pass_total;
    logic [63:0] drop_total;
    logic [63:0] source_hits;
    int          errors;
    int          pending;
    int          verdicts;
    int          drops;
    int          requests;
    int          idle_cycles;
    logic        sink_busy;
    logic        steady;
    logic [7:0]  frame[128];

    ipv4_blocklist_packet_filter dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_ready(in_ready), .i_mode(mode), .i_pkt_byte(pkt_byte),
        .i_pkt_last(pkt_last), .i_rule_slot(rule_slot), .i_rule_key(rule_key),
        .i_rule_enable(rule_enable), .o_valid(out_valid), .i_ready(out_ready),
        .o_verdict(verdict), .o_cause(cause), .o_pass_total(pass_total),
        .o_drop_total(drop_total), .o_source_hits(source_hits)
    );

    ipv4_blocklist_packet_filter_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .i_in_ready(in_ready), .i_mode(mode), .i_pkt_byte(pkt_byte),
        .i_pkt_last(pkt_last), .i_rule_slot(rule_slot), .i_rule_key(rule_key),
        .i_rule_enable(rule_enable), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_verdict(verdict), .i_cause(cause), .i_pass_total(pass_total),
        .i_drop_total(drop_total), .i_source_hits(source_hits), .o_errors(errors),
        .o_pending(pending), .o_verdicts(verdicts), .o_drops(drops)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side backpressure
    always @(posedge clk) begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 34);
    end

    // watchdog on cycles with no accepted request either way
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d quiet cycles", idle_cycles);
                $display("ipv4_blocklist_packet_filter_test: done, errors");
                $finish;
            end
        end
    end

    // one request, with random idle cycles ahead of it
    task automatic send(input t_mode m, input logic [7:0] b, input logic last,
                        input logic [3:0] slot, input logic [31:0] key, input logic en);
        while (!steady && $urandom_range(99) < 34) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        pkt_byte    <= b;
        pkt_last    <= last;
        rule_slot   <= slot;
        rule_key    <= key;
        rule_enable <= en;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests++;
    endtask

    task automatic send_rule(input t_mode m, input logic [3:0] slot, input logic [31:0] key,
                             input logic en);
        send(m, 8'($urandom), 1'($urandom), slot, key, en);
    endtask

    // push frame[0..len-1]
    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send(MODE_BYTE, frame[i], i == len - 1, 4'($urandom), $urandom, 1'($urandom));
    endtask

    // build an ipv4 header with given source, protocol, ihl and destination port
    task automatic build_ipv4(input logic [31:0] src, input logic [7:0] proto,
                              input logic [3:0] ihl, input logic [15:0] port);
        int l4;
        for (int i = 0; i < 128; i++) frame[i] = 8'($urandom);
        frame[12] = ETHERTYPE_IPV4[15:8];
        frame[13] = ETHERTYPE_IPV4[7:0];
        frame[14] = {4'h4, ihl};
        frame[23] = proto;
        {frame[26], frame[27], frame[28], frame[29]} = src;
        l4 = ETH_LEN + int'(ihl) * 4;
        if (l4 + 3 < 128) {frame[l4 + 2], frame[l4 + 3]} = port;
    endtask

    // hold off the sender until every expected verdict has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || out_valid) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_policy(input logic allow);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= allow;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    logic [31:0] src_pool[8];
    logic [15:0] port_pool[4];

    initial begin
        int len;
        int pick;
        logic [7:0] proto;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = 1'b0; in_valid = 1'b0;
        mode = MODE_BYTE; pkt_byte = '0; pkt_last = 1'b0; rule_slot = '0;
        rule_key = '0; rule_enable = 1'b0; steady = 1'b0;
        requests = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rules at the slot and key extremes
        send_rule(MODE_ADDR, 4'd0, 32'hFFFF_FFFF, 1'b1);
        send_rule(MODE_ADDR, 4'd15, 32'h0A00_0001, 1'b1);
        send_rule(MODE_TCP, 4'd15, 32'h0000_0050, 1'b1);
        send_rule(MODE_UDP, 4'd0, 32'hFFFF_FFFF, 1'b1);
        send_rule(MODE_UDP, 4'd3, 32'h0000_0035, 1'b0);
        // tiny frame, non-ipv4, short ipv4
        frame[0] = 8'hFF; send_frame(1);
        build_ipv4(32'h0102_0304, PROTO_TCP, 4'd5, 16'd1); frame[12] = 8'h86;
        send_frame(60);
        build_ipv4(32'h0102_0304, PROTO_TCP, 4'd5, 16'd1); send_frame(33);
        // blocked source, blocked tcp, blocked udp, deny, short l4, odd ihl, long frame
        build_ipv4(32'hFFFF_FFFF, PROTO_UDP, 4'd5, 16'd7); send_frame(60);
        build_ipv4(32'h0102_0304, PROTO_TCP, 4'd5, 16'h0050); send_frame(54);
        build_ipv4(32'h0102_0305, PROTO_UDP, 4'd5, 16'hFFFF); send_frame(42);
        build_ipv4(32'h0102_0305, PROTO_UDP, 4'd5, 16'h0035); send_frame(42);
        build_ipv4(32'h0102_0306, PROTO_TCP, 4'd5, 16'h0050); send_frame(53);
        build_ipv4(32'h0102_0306, PROTO_TCP, 4'd0, 16'h0050); send_frame(40);
        build_ipv4(32'h0102_0307, PROTO_UDP, 4'd15, 16'h0001); send_frame(128);
        build_ipv4(32'h0102_0307, 8'd1, 4'd5, 16'h0001); send_frame(128);
        set_policy(1'b1);
        build_ipv4(32'h0000_0000, PROTO_TCP, 4'd6, 16'h0000); send_frame(58);

        // random: rules from a small pool so matches happen, frames mostly well formed
        for (int i = 0; i < 8; i++) src_pool[i] = $urandom;
        for (int i = 0; i < 4; i++) port_pool[i] = 16'($urandom);
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1) set_policy(1'b0);
            if (phase == 2) begin
                set_policy(1'b1);
                steady = 1'b1;
            end
            if (phase == 3) begin
                steady = 1'b0;
                set_policy(1'b0);
            end
            while (requests < 700 + 240 * (phase + 1)) begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    send_rule(t_mode'($urandom_range(3, 1)), 4'($urandom),
                              $urandom_range(1) ? {16'h0, port_pool[$urandom_range(3)]}
                                                : src_pool[$urandom_range(7)],
                              1'($urandom));
                end else begin
                    proto = ($urandom_range(9) < 4) ? PROTO_TCP :
                            ($urandom_range(4) < 4) ? PROTO_UDP : 8'($urandom);
                    build_ipv4($urandom_range(9) < 8 ? src_pool[$urandom_range(7)]
                                                     : 32'($urandom),
                               proto, $urandom_range(9) < 8 ? 4'd5 : 4'($urandom),
                               port_pool[$urandom_range(3)]);
                    if (pick < 17) frame[12] = 8'($urandom);
                    len = (pick < 22) ? $urandom_range(40, 1) : $urandom_range(64, 34);
                    if (pick > 97) len = $urandom_range(127, 90);
                    send_frame(len);
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("sent %0d requests, checked %0d verdicts (%0d drops)",
                 requests, verdicts, drops);
        if (errors == 0 && pending == 0)
            $display("ipv4_blocklist_packet_filter_test: done, clean");
        else
            $display("ipv4_blocklist_packet_filter_test: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ipbf_pkg.sv
rtl/ipbf_parse.sv
rtl/ipbf_rules.sv
rtl/ipbf_sources.sv
rtl/ipv4_blocklist_packet_filter.sv
dv/ipv4_blocklist_packet_filter_checker.sv
dv/ipv4_blocklist_packet_filter_test.sv
